>>> hdl/pidsr_pkg.sv
// ----------------------------------------------------------------------------
// pidsr_pkg
// Shared widths, reset values and register indexes of the PID speed regulator.
// ----------------------------------------------------------------------------
package pidsr_pkg;

  localparam int SpeedW = 16;
  localparam int ErrW   = SpeedW + 1;
  localparam int GainW  = 24;
  localparam int DutyW  = 8;
  localparam int CfgAddrW = 3;

  localparam int InDataW  = 2 * SpeedW;
  localparam int OutDataW = DutyW;
  localparam int OutUserW = 1;

  localparam int DefGainFracBits = 16;
  localparam int DefSumWidth     = 32;

  localparam logic [GainW-1:0] KpRst      = GainW'(262144);
  localparam logic [GainW-1:0] KiDtRst    = GainW'(3932);
  localparam logic [GainW-1:0] KdDivDtRst = GainW'(3277);
  localparam logic signed [DutyW-1:0] OutMinRst = -8'sd100;
  localparam logic signed [DutyW-1:0] OutMaxRst = 8'sd100;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_KP        = 3'd0,
    CFG_KI_DT     = 3'd1,
    CFG_KD_DIV_DT = 3'd2,
    CFG_OUT_MIN   = 3'd3,
    CFG_OUT_MAX   = 3'd4
  } cfg_idx_t;

endpackage

>>> hdl/pid_speed_regulator.sv
// ----------------------------------------------------------------------------
// pid_speed_regulator
// Fixed-point PID speed controller with saturating error sum and duty clamp.
// ----------------------------------------------------------------------------
// pipeline: input register, then result register
// throughput: one transaction per cycle unless the output stalls, set by the
//   combinational PID datapath between the input and result registers
// reset: synchronous, clears the pipeline valids, error sum and last error,
//   and loads the default gains and limits
module pid_speed_regulator #(
  parameter int GAIN_FRAC_BITS = pidsr_pkg::DefGainFracBits,
  parameter int SUM_WIDTH      = pidsr_pkg::DefSumWidth
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] setpoint_speed, [31:16] measured_speed
  input  logic [pidsr_pkg::InDataW-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] duty
  output logic [pidsr_pkg::OutDataW-1:0]     out_tdata,
  // [0] clamped
  output logic [pidsr_pkg::OutUserW-1:0]     out_tuser,
  input  logic                               cfg_we,
  input  logic [pidsr_pkg::CfgAddrW-1:0]     cfg_addr,
  input  logic [pidsr_pkg::GainW-1:0]        cfg_wdata
);

  localparam int SpeedW = pidsr_pkg::SpeedW;
  localparam int ErrW   = pidsr_pkg::ErrW;
  localparam int GainW  = pidsr_pkg::GainW;
  localparam int DutyW  = pidsr_pkg::DutyW;
  localparam int PropW  = GainW + ErrW + 1;
  localparam int DervW  = GainW + ErrW + 2;
  localparam int IntgW  = GainW + SUM_WIDTH + 1;
  localparam int AccW   = GainW + SUM_WIDTH + 3;
  localparam int ValW   = AccW - GAIN_FRAC_BITS;
  localparam int OutDataW_L = pidsr_pkg::OutDataW;

  // configuration
  logic [GainW-1:0]        kp_r, ki_dt_r, kd_div_dt_r;
  logic signed [DutyW-1:0] out_min_r, out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= pidsr_pkg::KpRst;
      ki_dt_r     <= pidsr_pkg::KiDtRst;
      kd_div_dt_r <= pidsr_pkg::KdDivDtRst;
      out_min_r   <= pidsr_pkg::OutMinRst;
      out_max_r   <= pidsr_pkg::OutMaxRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pidsr_pkg::CFG_KP:        kp_r        <= cfg_wdata;
        pidsr_pkg::CFG_KI_DT:     ki_dt_r     <= cfg_wdata;
        pidsr_pkg::CFG_KD_DIV_DT: kd_div_dt_r <= cfg_wdata;
        pidsr_pkg::CFG_OUT_MIN:   out_min_r   <= $signed(cfg_wdata[DutyW-1:0]);
        pidsr_pkg::CFG_OUT_MAX:   out_max_r   <= $signed(cfg_wdata[DutyW-1:0]);
        default: ;
      endcase
    end
  end

  // input register
  logic                     s1_valid_r;
  logic signed [SpeedW-1:0] target_r, meas_r;
  logic                     advance;

  assign advance   = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      target_r <= $signed(in_tdata[SpeedW-1:0]);
      meas_r   <= $signed(in_tdata[2*SpeedW-1:SpeedW]);
    end
  end

  // controller state
  logic signed [SUM_WIDTH-1:0] error_sum_r, error_sum_nxt;
  logic signed [ErrW-1:0]      last_error_r, last_error_nxt;

  logic                        stop;
  logic signed [ErrW-1:0]      err;
  logic signed [ErrW:0]        diff;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [PropW-1:0]     p_term;
  logic signed [IntgW-1:0]     i_term;
  logic signed [DervW-1:0]     d_term;
  logic signed [AccW-1:0]      acc, acc_adj;
  logic signed [ValW-1:0]      val, min_ext, max_ext;
  logic signed [DutyW-1:0]     duty;
  logic                        clamped;

  assign stop = (target_r == '0);
  assign err  = {target_r[SpeedW-1], target_r} - {meas_r[SpeedW-1], meas_r};
  assign diff = {err[ErrW-1], err} - {last_error_r[ErrW-1], last_error_r};

  // saturating error sum
  assign sum_wide = {error_sum_r[SUM_WIDTH-1], error_sum_r}
                  + {{(SUM_WIDTH+1-ErrW){err[ErrW-1]}}, err};

  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  assign p_term = $signed({1'b0, kp_r}) * err;
  assign i_term = $signed({1'b0, ki_dt_r}) * sum_sat;
  assign d_term = $signed({1'b0, kd_div_dt_r}) * diff;

  assign acc = {{(AccW-PropW){p_term[PropW-1]}}, p_term}
             + {{(AccW-IntgW){i_term[IntgW-1]}}, i_term}
             + {{(AccW-DervW){d_term[DervW-1]}}, d_term};

  // bias negatives so the arithmetic shift truncates toward zero
  assign acc_adj = acc + {{(AccW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{acc[AccW-1]}}};
  assign val     = acc_adj[AccW-1:GAIN_FRAC_BITS];
  assign min_ext = {{(ValW-DutyW){out_min_r[DutyW-1]}}, out_min_r};
  assign max_ext = {{(ValW-DutyW){out_max_r[DutyW-1]}}, out_max_r};

  always_comb begin
    priority if (stop) begin
      duty    = '0;
      clamped = 1'b0;
    end else if (val > max_ext) begin
      duty    = out_max_r;
      clamped = 1'b1;
    end else if (val < min_ext) begin
      duty    = out_min_r;
      clamped = 1'b1;
    end else begin
      duty    = val[DutyW-1:0];
      clamped = 1'b0;
    end
  end

  always_comb begin
    error_sum_nxt  = error_sum_r;
    last_error_nxt = last_error_r;
    if (advance) begin
      if (stop) begin
        error_sum_nxt = '0;
      end else begin
        error_sum_nxt  = sum_sat;
        last_error_nxt = err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      error_sum_r  <= error_sum_nxt;
      last_error_r <= last_error_nxt;
    end
  end

  // result register
  logic                    out_valid_r;
  logic [OutDataW_L-1:0]   out_data_r;
  logic                    out_clamped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r    <= duty;
      out_clamped_r <= clamped;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clamped_r;

endmodule

>>> hdl/pidsr_checker.sv
// ----------------------------------------------------------------------------
// pidsr_checker
// Port-level checks of the PID speed regulator, bound to the top level.
// ----------------------------------------------------------------------------
module pidsr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [pidsr_pkg::InDataW-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pidsr_pkg::OutDataW-1:0] out_tdata,
  input logic [pidsr_pkg::OutUserW-1:0] out_tuser
);

  localparam int SpeedW = pidsr_pkg::SpeedW;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // no result straight after reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stop command reaches the output as zero duty, not clamped
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[SpeedW-1:0] == '0)
      ##1 (!out_tvalid || out_tready)
      |=> out_tvalid && (out_tdata == '0) && (out_tuser == '0))
    else $error("stop transaction gave nonzero duty");

endmodule

bind pid_speed_regulator pidsr_checker u_pidsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
